>>> rtl/core/bwl_pkg.sv
// ----------------------------------------------------------------------------
// Band-limited wavetable lookup package
// Shared types, codes and constants of the wavetable oscillator lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package bwl_pkg;

  // Number of band subtables per shape.
  localparam int unsigned BANDS            = 14;
  // Default table geometry.
  localparam int unsigned SHAPES_DEF       = 4;
  localparam int unsigned TABLE_LENGTH_DEF = 256;
  // Width of one table entry and of the output sample.
  localparam int unsigned SAMPLE_W         = 16;

  // Band edges in whole Hz, ascending; compared against Q16.8 frequencies.
  localparam logic [15:0] BAND_EDGE_HZ [BANDS-1] = '{
    16'd122,  16'd176,  16'd254,  16'd367,  16'd531,  16'd766,  16'd1107,
    16'd1599, 16'd2309, 16'd3336, 16'd4818, 16'd6960, 16'd10053
  };

  typedef enum logic {
    CMD_PLAY  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [1:0]         shape;
    logic [23:0]        frequency;
    logic signed [15:0] phase;
    logic [3:0]         write_band;
    logic [8:0]         write_position;
    logic signed [15:0] write_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         band;
  } out_t;

endpackage : bwl_pkg

`default_nettype wire

>>> rtl/core/bwl_table.sv
// ----------------------------------------------------------------------------
// Wavetable storage
// Single-write, dual-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bwl_table #(
  parameter int unsigned DEPTH = bwl_pkg::SHAPES_DEF * bwl_pkg::BANDS *
                                 (bwl_pkg::TABLE_LENGTH_DEF + 1),
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [AW-1:0]                       wr_addr,
  input  wire logic signed [bwl_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic                                rd_en,
  input  wire logic [AW-1:0]                       rd_addr_a,
  input  wire logic [AW-1:0]                       rd_addr_b,
  output logic signed [bwl_pkg::SAMPLE_W-1:0]      rd_data_a_r,
  output logic signed [bwl_pkg::SAMPLE_W-1:0]      rd_data_b_r
);

  logic signed [bwl_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // Contents are undefined until written, so the array has no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= mem[rd_addr_a];
      rd_data_b_r <= mem[rd_addr_b];
    end
  end

endmodule : bwl_table

`default_nettype wire

>>> rtl/core/bandlimited_wavetable_lookup.sv
// ----------------------------------------------------------------------------
// Band-limited wavetable lookup
// Picks a band subtable from the frequency, maps the phase to a table index
// and fraction, and linearly interpolates between neighbouring entries.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                          Carries
//   -------  -----------------------------  ----------------------------------
//   input    in_valid, in_stall, in_data    play or table-write transaction
//   output   out_valid, out_stall, out_data interpolated sample and band
//
// One transaction is accepted per cycle when the pipeline is not backed up.
// A play transaction passes the stage 1 register, the registered dual-read
// table memory, one multiply stage and one add stage before its result is
// registered at the output. Write transactions produce no result.
// Reset clears only the stage valid flags; the table contents are undefined
// until written. Each stage holds when the stage after it is full and stalled,
// so empty stages keep absorbing transactions while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bandlimited_wavetable_lookup #(
  parameter int unsigned SHAPES       = bwl_pkg::SHAPES_DEF,
  parameter int unsigned TABLE_LENGTH = bwl_pkg::TABLE_LENGTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bwl_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bwl_pkg::out_t      out_data
);

  // Table geometry: each subtable carries one guard entry past the end.
  localparam int unsigned Entries = TABLE_LENGTH + 1;
  localparam int unsigned Rows    = SHAPES * bwl_pkg::BANDS;
  localparam int unsigned Depth   = Rows * Entries;
  localparam int unsigned Aw      = $clog2(Depth);
  localparam int unsigned Rw      = $clog2(Rows);
  localparam int unsigned Iw      = $clog2(TABLE_LENGTH);
  localparam int unsigned Pw      = 16 + Iw;

  // --------------------------------------------------------------------------
  // Input decode: band choice, shape wrap and phase to position.
  // --------------------------------------------------------------------------
  logic [3:0]    band_cnt;
  logic [1:0]    shape_wrap;
  logic [15:0]   phase_u;
  logic [Pw-1:0] pos;
  int            sh;

  always_comb begin
    // The edges ascend, so counting the edges passed gives the band.
    band_cnt = '0;
    for (int i = 0; i < int'(bwl_pkg::BANDS) - 1; i++) begin
      band_cnt = band_cnt +
                 4'(in_data.frequency >= {bwl_pkg::BAND_EDGE_HZ[i], 8'h00});
    end
  end

  always_comb begin
    // Shape is taken modulo the number of table sets.
    sh = int'(in_data.shape);
    for (int k = 0; k < 4; k++) begin
      if (sh >= int'(SHAPES)) begin
        sh = sh - int'(SHAPES);
      end
    end
    shape_wrap = 2'(sh);
  end

  // Offset the signed phase into an unsigned fraction of a cycle.
  assign phase_u = {~in_data.phase[15], in_data.phase[14:0]};
  assign pos     = Pw'(phase_u) * Pw'(TABLE_LENGTH);

  // --------------------------------------------------------------------------
  // Pipeline handshake. A stage loads when it is empty or its content moves.
  // The input is stalled throughout reset, so no transaction is taken then.
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_valid_nxt, s2_valid_nxt, s3_valid_nxt, out_valid_nxt;
  logic ld_out, ld_s3, ld_s2, ld_s1;

  assign ld_out   = !out_valid_r || !out_stall;
  assign ld_s3    = !s3_valid_r || ld_out;
  assign ld_s2    = !s2_valid_r || ld_s3;
  assign ld_s1    = !s1_valid_r || ld_s2;
  assign in_stall = !ld_s1 || !rst_n;

  // --------------------------------------------------------------------------
  // Stage 1: registered transaction.
  // --------------------------------------------------------------------------
  bwl_pkg::cmd_t      s1_cmd_r;
  logic [1:0]         s1_shape_r;
  logic [3:0]         s1_band_r;
  logic [Iw-1:0]      s1_idx_r;
  logic [15:0]        s1_frac_r;
  logic [3:0]         s1_wband_r;
  logic [8:0]         s1_wpos_r;
  logic signed [15:0] s1_wsample_r;

  always_ff @(posedge clk) begin
    if (ld_s1) begin
      s1_cmd_r     <= in_data.command;
      s1_shape_r   <= shape_wrap;
      s1_band_r    <= band_cnt;
      s1_idx_r     <= pos[Pw-1:16];
      s1_frac_r    <= pos[15:0];
      s1_wband_r   <= in_data.write_band;
      s1_wpos_r    <= in_data.write_position;
      s1_wsample_r <= in_data.write_sample;
    end
  end

  // Table addressing for both commands.
  logic [Rw-1:0] rd_row, wr_row;
  logic [Aw-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic          wr_ok, tbl_wr_en, tbl_rd_en;

  always_comb begin
    rd_row    = Rw'(s1_shape_r) * Rw'(bwl_pkg::BANDS) + Rw'(s1_band_r);
    rd_addr_a = Aw'(rd_row) * Aw'(Entries) + Aw'(s1_idx_r);
    rd_addr_b = rd_addr_a + Aw'(1);
    wr_row    = Rw'(s1_shape_r) * Rw'(bwl_pkg::BANDS) + Rw'(s1_wband_r);
    wr_addr   = Aw'(wr_row) * Aw'(Entries) + Aw'(s1_wpos_r);
    // Writes beyond the band list or past the guard entry are dropped.
    wr_ok     = (32'(s1_wband_r) < 32'(bwl_pkg::BANDS)) &&
                (32'(s1_wpos_r) <= 32'(TABLE_LENGTH));
  end

  // The table is touched only as stage 1 hands on, so accesses keep order.
  assign tbl_wr_en = ld_s2 && s1_valid_r && (s1_cmd_r == bwl_pkg::CMD_WRITE) && wr_ok;
  assign tbl_rd_en = ld_s2 && s1_valid_r && (s1_cmd_r == bwl_pkg::CMD_PLAY);

  // --------------------------------------------------------------------------
  // Stage 2: table read data arrives here.
  // --------------------------------------------------------------------------
  logic signed [15:0] ent_a, ent_b;
  logic [15:0]        s2_frac_r;
  logic [3:0]         s2_band_r;

  bwl_table #(
    .DEPTH (Depth)
  ) u_table (
    .clk         (clk),
    .wr_en       (tbl_wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (s1_wsample_r),
    .rd_en       (tbl_rd_en),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .rd_data_a_r (ent_a),
    .rd_data_b_r (ent_b)
  );

  always_ff @(posedge clk) begin
    if (ld_s2) begin
      s2_frac_r <= s1_frac_r;
      s2_band_r <= s1_band_r;
    end
  end

  // Slope times fraction; the product stays below 2^32 in magnitude.
  logic signed [16:0] diff;
  logic signed [33:0] prod;

  assign diff = {ent_b[15], ent_b} - {ent_a[15], ent_a};
  assign prod = $signed({1'b0, s2_frac_r}) * diff;

  // --------------------------------------------------------------------------
  // Stage 3: the floored step is bits 31:16 of the product, as only the low
  // sixteen bits of the sum are kept.
  // --------------------------------------------------------------------------
  logic signed [15:0] s3_a_r, s3_step_r;
  logic [3:0]         s3_band_r;

  always_ff @(posedge clk) begin
    if (ld_s3) begin
      s3_a_r    <= ent_a;
      s3_step_r <= prod[31:16];
      s3_band_r <= s2_band_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic signed [15:0] out_sample_r;
  logic [3:0]         out_band_r;

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_sample_r <= s3_a_r + s3_step_r;
      out_band_r   <= s3_band_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data.sample = out_sample_r;
  assign out_data.band   = out_band_r;

  // --------------------------------------------------------------------------
  // Valid flags. Write transactions leave the pipeline at stage 1.
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt  = ld_s1  ? in_valid : s1_valid_r;
    s2_valid_nxt  = ld_s2  ? (s1_valid_r && (s1_cmd_r == bwl_pkg::CMD_PLAY)) : s2_valid_r;
    s3_valid_nxt  = ld_s3  ? s2_valid_r : s3_valid_r;
    out_valid_nxt = ld_out ? s3_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule : bandlimited_wavetable_lookup

`default_nettype wire

>>> bench/bandlimited_wavetable_lookup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Band-limited wavetable lookup testbench
// Loads table entries through write transactions and checks every interpolated
// sample and band choice against an in-bench shadow of the table. The random
// part keeps each play inside written entries and reaches every band edge.
// ----------------------------------------------------------------------------

module bandlimited_wavetable_lookup_tb;

  localparam int unsigned N_SHAPES       = 4;
  localparam int unsigned N_BANDS        = 14;
  localparam int unsigned TBL_LEN        = 256;
  // Used with a margin to size the wait that covers the tail of the run.
  localparam int unsigned PIPE_LATENCY   = 3;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // Band ladder in whole Hz. The frequency is Q16.8, so each edge is shifted
  // left by eight bits before it is compared.
  localparam logic [15:0] EDGE_HZ [N_BANDS-1] = '{
    16'd122,  16'd176,  16'd254,  16'd367,  16'd531,  16'd766,  16'd1107,
    16'd1599, 16'd2309, 16'd3336, 16'd4818, 16'd6960, 16'd10053
  };

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  bwl_pkg::in_t  in_data   = '0;
  logic          in_stall;
  logic          out_valid;
  logic          out_stall = 1'b0;
  bwl_pkg::out_t out_data;

  bandlimited_wavetable_lookup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Shadow of the table as the block should hold it, updated in transaction
  // order by the input monitor.
  logic signed [15:0] entry_shadow [N_SHAPES][N_BANDS][TBL_LEN+1];
  // Entries that the stimulus has already written. Plays never touch an entry
  // that is missing here, because such reads are undefined.
  bit                 entry_loaded [N_SHAPES][N_BANDS][TBL_LEN+1];
  // Samples still owed by the block, oldest first.
  bwl_pkg::out_t      owed_samples [$];
  bwl_pkg::out_t      oldest_owed;

  int unsigned        gap_pct      = 0;
  int unsigned        stall_pct    = 0;
  int unsigned        error_count  = 0;
  int unsigned        idle_cycles  = 0;
  int unsigned        items_sent   = 0;
  int unsigned        plays_checked = 0;
  int unsigned        writes_seen  = 0;
  int unsigned        ignored_seen = 0;
  logic [N_BANDS-1:0] bands_hit    = '0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // The band is the number of edges at or below the frequency; the ladder is
  // ascending, so counting is enough.
  function automatic logic [3:0] band_of(logic [23:0] freq);
    logic [3:0] bnd;
    bnd = '0;
    for (int k = 0; k < N_BANDS - 1; k++) begin
      if (freq >= {EDGE_HZ[k], 8'h00}) begin
        bnd++;
      end
    end
    return bnd;
  endfunction

  // Offset binary phase: the top eight bits select the entry and the low eight
  // bits, moved up to a 16-bit fraction, weight the step to the next entry.
  // The product is shifted arithmetically, which floors it towards minus
  // infinity as the block does.
  function automatic bwl_pkg::out_t interpolate(bwl_pkg::in_t item);
    bwl_pkg::out_t      res;
    logic [15:0]        u;
    logic [7:0]         idx;
    logic signed [16:0] frac;
    logic signed [17:0] a;
    logic signed [17:0] b;
    logic signed [17:0] diff;
    logic signed [17:0] sum;
    logic signed [35:0] prod;
    logic signed [35:0] scaled;
    res.band = band_of(item.frequency);
    u        = item.phase ^ 16'h8000;
    idx      = u[15:8];
    frac     = {1'b0, u[7:0], 8'h00};
    a        = entry_shadow[item.shape][res.band][idx];
    b        = entry_shadow[item.shape][res.band][int'(idx) + 1];
    diff     = b - a;
    prod     = frac * diff;
    scaled   = prod >>> 16;
    sum      = a + scaled[17:0];
    res.sample = sum[15:0];
    return res;
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endfunction

  // Input monitor: every accepted transaction updates the shadow or owes a
  // sample, in the order that the block accepted them.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      if (in_data.command == bwl_pkg::CMD_WRITE) begin
        writes_seen++;
        if (in_data.write_band < N_BANDS && in_data.write_position <= TBL_LEN) begin
          entry_shadow[in_data.shape][in_data.write_band][in_data.write_position] =
            in_data.write_sample;
        end else begin
          ignored_seen++;
        end
      end else begin
        owed_samples.push_back(interpolate(in_data));
      end
    end
  end

  // Result checker: each accepted result is matched against the oldest sample
  // still owed, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_samples.size() == 0) begin
        report_error($sformatf("result with nothing owed: sample %0d band %0d",
                               out_data.sample, out_data.band));
      end else begin
        oldest_owed = owed_samples.pop_front();
        plays_checked++;
        bands_hit[oldest_owed.band] = 1'b1;
        if (out_data.sample !== oldest_owed.sample) begin
          report_error($sformatf("sample: expected %0d, got %0d (band %0d)",
                                 oldest_owed.sample, out_data.sample, oldest_owed.band));
        end
        if (out_data.band !== oldest_owed.band) begin
          report_error($sformatf("band: expected %0d, got %0d",
                                 oldest_owed.band, out_data.band));
        end
      end
    end
  end

  // The receiver stalls at random, at whatever rate the current phase sets.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a healthy run never goes long without a transaction on one side
  // or the other, even under the heaviest stalling.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timed out after %0d cycles with no transaction, %0d samples owed.",
                 idle_cycles, owed_samples.size());
        $display("bandlimited_wavetable_lookup_tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Presents one transaction and returns at the edge that accepts it. Valid is
  // left high, so the next call may present its transaction straight away; a
  // gap lowers valid first and waits at least one edge before raising it.
  task automatic send_item(bwl_pkg::in_t item);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Every field random, so that the fields a command ignores still toggle.
  function automatic bwl_pkg::in_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(bwl_pkg::in_t)-1:0];
  endfunction

  // Full-scale values turn up often, since they stress the difference term.
  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] random_phase();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Much of the time the frequency sits within a couple of LSBs of an edge,
  // so that every comparison in the ladder is exercised on both sides.
  function automatic logic [23:0] random_freq();
    int unsigned k;
    k = $urandom_range(N_BANDS - 2);
    case ($urandom_range(9))
      0, 1, 2: return {EDGE_HZ[k], 8'h00} + 24'($urandom_range(3)) - 24'd2;
      3, 4:    return 24'($urandom);
      default: return 24'($urandom_range(12000 * 256));
    endcase
  endfunction

  task automatic put_entry(logic [1:0] shape, logic [3:0] band, logic [8:0] pos,
                           logic signed [15:0] value);
    bwl_pkg::in_t item;
    item                = random_item();
    item.command        = bwl_pkg::CMD_WRITE;
    item.shape          = shape;
    item.write_band     = band;
    item.write_position = pos;
    item.write_sample   = value;
    entry_loaded[shape][band][pos] = 1'b1;
    send_item(item);
  endtask

  // A write that the block must drop, with either the band or the position
  // beyond the table.
  task automatic put_ignored(logic [1:0] shape, logic [3:0] band, logic [8:0] pos);
    bwl_pkg::in_t item;
    item                = random_item();
    item.command        = bwl_pkg::CMD_WRITE;
    item.shape          = shape;
    item.write_band     = band;
    item.write_position = pos;
    send_item(item);
  endtask

  // Plays one sample. The two entries it reads are written first if they have
  // never been loaded, or always when reload is set; the play then follows
  // the writes directly, which tests reads of freshly written entries.
  task automatic play(logic [1:0] shape, logic [23:0] freq, logic signed [15:0] phase,
                      bit reload);
    bwl_pkg::in_t item;
    logic [3:0]   bnd;
    logic [15:0]  u;
    int unsigned  idx;
    bnd = band_of(freq);
    u   = phase ^ 16'h8000;
    idx = u[15:8];
    for (int k = 0; k < 2; k++) begin
      if (reload || !entry_loaded[shape][bnd][idx + k]) begin
        put_entry(shape, bnd, 9'(idx + k), random_sample());
      end
    end
    item           = random_item();
    item.command   = bwl_pkg::CMD_PLAY;
    item.shape     = shape;
    item.frequency = freq;
    item.phase     = phase;
    send_item(item);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Writes beyond a subtable or beyond the last band must not land anywhere.
  // The entries nearest to where a careless address would alias are loaded
  // first and read back afterwards.
  task automatic test_out_of_range_writes();
    put_entry(2'd0, 4'd0, 9'd255, random_sample());
    put_entry(2'd0, 4'd0, 9'd256, random_sample());
    put_entry(2'd0, 4'd1, 9'd0,   random_sample());
    put_entry(2'd0, 4'd1, 9'd1,   random_sample());
    put_entry(2'd1, 4'd0, 9'd0,   random_sample());
    put_entry(2'd1, 4'd0, 9'd1,   random_sample());
    put_ignored(2'd0, 4'd0,  9'd257);
    put_ignored(2'd0, 4'd0,  9'd511);
    put_ignored(2'd0, 4'd14, 9'd0);
    put_ignored(2'd0, 4'd15, 9'd1);
    play(2'd0, 24'd0,             16'sh7F80, 1'b0);
    play(2'd0, {16'd122, 8'h00},  16'sh8000, 1'b0);
    play(2'd1, 24'd0,             16'sh8000, 1'b0);
  endtask

  // Both sides of the lowest and highest edges, plus the frequency extremes.
  task automatic test_band_ladder();
    play(2'd2, 24'd0,                           16'sh0000, 1'b0);
    play(2'd2, {16'd122, 8'h00} - 24'd1,        16'sh0000, 1'b0);
    play(2'd2, {16'd122, 8'h00},                16'sh0000, 1'b0);
    play(2'd2, {16'd10053, 8'h00} - 24'd1,      16'sh0000, 1'b0);
    play(2'd2, {16'd10053, 8'h00},              16'sh0000, 1'b0);
    play(2'd2, 24'hFF_FFFF,                     16'sh0000, 1'b0);
  endtask

  // Phase extremes over full-scale steps: the first entry, the guard entry at
  // the top, the middle, and fractions at both ends of their range.
  task automatic test_phase_extremes();
    put_entry(2'd3, 4'd0, 9'd0,   16'sh7FFF);
    put_entry(2'd3, 4'd0, 9'd1,   16'sh8000);
    put_entry(2'd3, 4'd0, 9'd128, 16'sh8000);
    put_entry(2'd3, 4'd0, 9'd129, 16'sh7FFF);
    put_entry(2'd3, 4'd0, 9'd255, 16'sh8000);
    put_entry(2'd3, 4'd0, 9'd256, 16'sh7FFF);
    play(2'd3, 24'd0, 16'sh8000, 1'b0);
    play(2'd3, 24'd0, 16'sh8001, 1'b0);
    play(2'd3, 24'd0, 16'sh7FFF, 1'b0);
    play(2'd3, 24'd0, 16'sh0000, 1'b0);
    play(2'd3, 24'd0, 16'sh00FF, 1'b0);
    play(2'd3, 24'd0, 16'shFFFF, 1'b0);
  endtask

  // Mostly plays, each preceded where needed by the writes of its entries and
  // sometimes by a fresh rewrite of them; the rest are loose writes to any
  // entry and writes that the block must drop.
  task automatic run_random(int unsigned target);
    int unsigned start;
    int unsigned roll;
    start = items_sent;
    while (items_sent - start < target) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        play(2'($urandom), random_freq(), random_phase(), $urandom_range(99) < 30);
      end else if (roll < 88) begin
        put_entry(2'($urandom), 4'($urandom_range(N_BANDS - 1)),
                  9'($urandom_range(TBL_LEN)), random_sample());
      end else if (roll < 94) begin
        put_ignored(2'($urandom), 4'($urandom_range(15, N_BANDS)), 9'($urandom));
      end else begin
        put_ignored(2'($urandom), 4'($urandom_range(N_BANDS - 1)),
                    9'($urandom_range(511, TBL_LEN + 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender gaps light, receiver stalls heavy.
    gap_pct   = 11;
    stall_pct = 51;
    test_out_of_range_writes();
    test_band_ladder();
    test_phase_extremes();
    run_random(170);

    // The other way round.
    gap_pct   = 51;
    stall_pct = 11;
    run_random(170);

    // Back to back on both sides.
    gap_pct   = 0;
    stall_pct = 0;
    run_random(170);

    in_valid <= 1'b0;
    while (owed_samples.size() != 0) @(posedge clk);
    // Anything the block emits after this point is a result with nothing owed.
    repeat (PIPE_LATENCY + 5) @(posedge clk);

    $display("Checked %0d samples over %0d of %0d bands; %0d table writes, %0d dropped.",
             plays_checked, $countones(bands_hit), N_BANDS, writes_seen, ignored_seen);
    $display("Idling ran light-gap/heavy-stall, then reversed, then none at all.");
    if (error_count == 0) begin
      $display("bandlimited_wavetable_lookup_tb: clean");
    end else begin
      $display("%0d mismatches in total.", error_count);
      $display("bandlimited_wavetable_lookup_tb: errors");
    end
    $finish;
  end

endmodule
